### rtl/digit_plurality_vote_filter_defines.svh
// ----------------------------------------------------------------------------
// Digit plurality vote filter assertion macros
// Clocked assertion shorthands shared by the vote filter RTL.
// ----------------------------------------------------------------------------
`ifndef DIGIT_PLURALITY_VOTE_FILTER_DEFINES_SVH
`define DIGIT_PLURALITY_VOTE_FILTER_DEFINES_SVH

// check a property on every clock edge outside reset
`define DPVF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition is followed by another on the next edge
`define DPVF_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) else $error(msg);

`endif

### rtl/dpvf_pkg.sv
// ----------------------------------------------------------------------------
// Digit plurality vote filter package
// Sizes, codes, item types and digit helpers for the vote filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dpvf_pkg;

	localparam int NUM_BINS    = 8;
	localparam int TALLY_WIDTH = 16;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int NUM_TALLIES = 3;
	localparam int MEM_DEPTH   = NUM_TALLIES * NUM_BINS;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int PAIR_DEPTH  = 2 * NUM_BINS;

	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] DIGIT_LO   = 8'(48 + 1);
	localparam logic [7:0] DIGIT_HI   = 8'(48 + NUM_BINS);

	localparam logic [BIN_W-1:0]       BIN_LAST  = BIN_W'(NUM_BINS - 1);
	localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = {TALLY_WIDTH{1'b1}};

	// item kinds
	localparam logic [1:0] KIND_PAIR   = 2'd0;
	localparam logic [1:0] KIND_SINGLE = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// side modes
	localparam logic [1:0] SIDE_LEFT   = 2'd0;
	localparam logic [1:0] SIDE_MIDDLE = 2'd1;
	localparam logic [1:0] SIDE_RIGHT  = 2'd2;

	// tally selects
	localparam logic [1:0] TALLY_PAIR0  = 2'd0;
	localparam logic [1:0] TALLY_PAIR1  = 2'd1;
	localparam logic [1:0] TALLY_TARGET = 2'd2;

	// configuration register indexes
	localparam logic REG_SIDE_MODE  = 1'b0;
	localparam logic REG_VOTE_COUNT = 1'b1;

	localparam logic [1:0] SIDE_MODE_RESET  = SIDE_MIDDLE;
	localparam logic [7:0] VOTE_COUNT_RESET = 8'd30;
	localparam logic [7:0] COUNT_MAX        = 8'd255;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] first_char;
		logic [7:0] second_char;
	} item_t;

	typedef struct packed {
		logic [3:0] slot_left_far;
		logic [3:0] slot_left_near;
		logic [3:0] slot_right_near;
		logic [3:0] slot_right_far;
		logic [3:0] target_number;
		logic       target_decided;
		logic       switch_request;
		logic       bad_digit;
	} result_t;

	function automatic logic digit_ok(input logic [7:0] ch);
		return (ch >= DIGIT_LO) && (ch <= DIGIT_HI);
	endfunction

	function automatic logic [BIN_W-1:0] digit_bin(input logic [7:0] ch);
		logic [7:0] d;
		d = ch - DIGIT_LO;
		return d[BIN_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] tally_addr(input logic [1:0] tsel,
		input logic [BIN_W-1:0] bin);
		return ADDR_W'(32'(tsel) * NUM_BINS + 32'(bin));
	endfunction

	function automatic logic [3:0] vote_value(input logic [BIN_W-1:0] bin);
		return 4'(32'(bin) + 1);
	endfunction

endpackage

`default_nettype wire

### rtl/digit_plurality_vote_filter.sv
// ----------------------------------------------------------------------------
// Digit plurality vote filter
// Tallies digit reports in a tally memory and reports plurality votes.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  item     | item_valid / item_stall  | item   (mode, first_char, second_char)
//  result   | result_valid/result_stall| result (slots, target, flags)
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
//  Pair item: two read-modify-writes, then an argmax scan of both 8-entry pair tallies.
//  Single item: one read-modify-write, plus an 8-entry scan when a round completes.
//  Clear and unused kinds go straight to output. All tallies sit behind one memory port.
//  Reset zeroes tallies through per-entry valid bits; no clearing pass.
//  A stalled result holds in the output register; the next item waits.
`default_nettype none
`include "digit_plurality_vote_filter_defines.svh"

module digit_plurality_vote_filter (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire dpvf_pkg::item_t item,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output dpvf_pkg::result_t    result,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic            cfg_index,
	input  wire logic [7:0]      cfg_data
);
	import dpvf_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_BUMP_RD = 7'b0000010,
		ST_BUMP_WR = 7'b0000100,
		ST_SCAN    = 7'b0001000,
		ST_FLUSH   = 7'b0010000,
		ST_OUT     = 7'b0100000,
		ST_SPARE   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [TALLY_WIDTH-1:0] mem [0:MEM_DEPTH-1];
	logic [MEM_DEPTH-1:0]   vld_q;

	logic [1:0]  side_mode_q;
	logic [7:0]  vote_count_q;
	logic [7:0]  single_cnt_q;
	logic [3:0]  slot_q [0:3];
	logic [3:0]  target_q;

	logic [1:0]        kind_q;
	logic              bad_q;
	logic              dec_q;
	logic [ADDR_W-1:0] bump_addr_q [0:1];
	logic [1:0]        bump_en_q;
	logic              bump_sel_q;
	logic [1:0]        tsel_q;
	logic [BIN_W-1:0]  bin_q;

	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [TALLY_WIDTH-1:0] rd_data_s1;
	logic                   rd_vld_s1;
	logic                   pend_s1;
	logic [1:0]             tsel_s1;
	logic [BIN_W-1:0]       bin_s1;

	logic [TALLY_WIDTH-1:0] best_q;
	logic [BIN_W-1:0]       best_idx_q;

	logic                   accept;
	logic                   out_load;
	logic [TALLY_WIDTH-1:0] eff;
	logic [TALLY_WIDTH-1:0] bumped;
	logic [3:0]             win;
	logic [7:0]             cnt_inc;
	logic                   ok0;
	logic                   ok1;
	logic [1:0]             tsel_end;
	logic                   mem_we;

	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign accept     = item_valid && !item_stall;
	assign out_load   = (state_q == ST_OUT) && (!result_valid || !result_stall);

	assign ok0      = digit_ok(item.first_char);
	assign ok1      = digit_ok(item.second_char);
	assign cnt_inc  = (single_cnt_q == COUNT_MAX) ? COUNT_MAX : single_cnt_q + 8'd1;
	assign tsel_end = (kind_q == KIND_PAIR) ? TALLY_PAIR1 : TALLY_TARGET;

	assign eff    = rd_vld_s1 ? rd_data_s1 : '0;
	assign bumped = (eff == TALLY_MAX) ? TALLY_MAX : eff + 1'b1;
	assign win    = (eff > best_q) ? vote_value(bin_s1) : vote_value(best_idx_q);
	assign mem_we = (state_q == ST_BUMP_WR) && bump_en_q[bump_sel_q];

	assign rd_en   = (state_q == ST_BUMP_RD) || (state_q == ST_SCAN);
	assign rd_addr = (state_q == ST_SCAN) ? tally_addr(tsel_q, bin_q)
		: bump_addr_q[bump_sel_q];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_mode_q  <= SIDE_MODE_RESET;
			vote_count_q <= VOTE_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SIDE_MODE:  side_mode_q  <= cfg_data[1:0];
				REG_VOTE_COUNT: vote_count_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// tally memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[bump_addr_q[bump_sel_q]] <= bumped;
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			pend_s1   <= 1'b0;
			tsel_s1   <= TALLY_PAIR0;
			bin_s1    <= '0;
		end else begin
			if (accept && item.mode == KIND_CLEAR)
				vld_q[PAIR_DEPTH-1:0] <= '0;
			else if (mem_we)
				vld_q[bump_addr_q[bump_sel_q]] <= 1'b1;
			if (rd_en)
				rd_vld_s1 <= vld_q[rd_addr];
			pend_s1 <= (state_q == ST_SCAN);
			tsel_s1 <= tsel_q;
			bin_s1  <= bin_q;
		end
	end

	// argmax tracking
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			if (bin_s1 == '0) begin
				best_q     <= eff;
				best_idx_q <= '0;
			end else if (eff > best_q) begin
				best_q     <= eff;
				best_idx_q <= bin_s1;
			end
		end
	end

	// slots and decided target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				slot_q[i] <= 4'd0;
			target_q <= 4'd0;
		end else if (pend_s1 && bin_s1 == BIN_LAST) begin
			if (tsel_s1 == TALLY_TARGET)
				target_q <= win;
			else if (side_mode_q inside {SIDE_LEFT, SIDE_MIDDLE, SIDE_RIGHT})
				slot_q[2'(side_mode_q + tsel_s1)] <= win;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			single_cnt_q <= 8'd0;
			kind_q       <= KIND_PAIR;
			bad_q        <= 1'b0;
			dec_q        <= 1'b0;
			bump_en_q    <= 2'b00;
			bump_sel_q   <= 1'b0;
			tsel_q       <= TALLY_PAIR0;
			bin_q        <= '0;
			bump_addr_q[0] <= '0;
			bump_addr_q[1] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q     <= item.mode;
						bump_sel_q <= 1'b0;
						bad_q      <= 1'b0;
						dec_q      <= 1'b0;
						bump_en_q  <= 2'b00;
						case (item.mode)
							KIND_PAIR: begin
								bump_en_q      <= {ok1, ok0};
								bump_addr_q[0] <= tally_addr(TALLY_PAIR0,
									digit_bin(item.first_char));
								bump_addr_q[1] <= tally_addr(TALLY_PAIR1,
									digit_bin(item.second_char));
								bad_q          <= !ok0 || !ok1;
								state_q        <= ST_BUMP_RD;
							end
							KIND_SINGLE: begin
								bump_en_q      <= {1'b0, ok0};
								bump_addr_q[0] <= tally_addr(TALLY_TARGET,
									digit_bin(item.first_char));
								bad_q          <= !ok0;
								if (cnt_inc >= vote_count_q) begin
									dec_q        <= 1'b1;
									single_cnt_q <= 8'd0;
								end else begin
									single_cnt_q <= cnt_inc;
								end
								state_q <= ST_BUMP_RD;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_BUMP_RD: state_q <= ST_BUMP_WR;
				ST_BUMP_WR: begin
					if (!bump_sel_q && kind_q == KIND_PAIR) begin
						bump_sel_q <= 1'b1;
						state_q    <= ST_BUMP_RD;
					end else if (kind_q == KIND_PAIR || dec_q) begin
						tsel_q  <= (kind_q == KIND_PAIR) ? TALLY_PAIR0 : TALLY_TARGET;
						bin_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					if (bin_q == BIN_LAST) begin
						bin_q <= '0;
						if (tsel_q == tsel_end)
							state_q <= ST_FLUSH;
						else
							tsel_q <= tsel_q + 2'd1;
					end else begin
						bin_q <= bin_q + 1'b1;
					end
				end
				ST_FLUSH: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result.slot_left_far   <= slot_q[0];
			result.slot_left_near  <= slot_q[1];
			result.slot_right_near <= slot_q[2];
			result.slot_right_far  <= slot_q[3];
			result.target_number   <= target_q;
			result.target_decided  <= dec_q;
			result.switch_request  <= dec_q;
			result.bad_digit       <= bad_q;
		end
	end

	`DPVF_ASSERT(a_pend_after_scan, !pend_s1 || $past(state_q) == ST_SCAN, "compare without scan read")
	`DPVF_ASSERT(a_slot_from_scan, $stable(slot_q[0]) && $stable(slot_q[1]) && $stable(slot_q[2]) && $stable(slot_q[3]) || $past(pend_s1), "slot changed outside scan")
	`DPVF_ASSERT(a_result_from_out, !$rose(result_valid) || $past(state_q) == ST_OUT, "result raised outside output state")
	`DPVF_ASSERT_NEXT(a_dec_single, state_q == ST_OUT && dec_q, kind_q == KIND_SINGLE || state_q == ST_IDLE, "decision on non-single item")

endmodule

`default_nettype wire
